@@ src/adpcmd_pkg.sv @@
package adpcmd_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned NibW     = 4;
	localparam int unsigned CoefW    = 16;
	localparam int unsigned SampleW  = 16;
	localparam int unsigned ProdW    = 2 * CoefW;
	localparam int unsigned AccW     = ProdW + 2;
	localparam int unsigned PredSh   = 11;
	localparam int unsigned PredW    = AccW - PredSh;
	localparam int unsigned NibShW   = NibW + 16;
	localparam int unsigned SumW     = PredW + 2;
	localparam int unsigned PosW     = 3;
	localparam int unsigned HdrW     = 7;
	localparam int unsigned NumBanks = 4;
	localparam int unsigned BankSelW = $clog2(NumBanks);
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = NumBanks * CoefW;

	localparam logic [PosW-1:0]          FirstDataPos = PosW'(1);
	localparam logic [PosW-1:0]          LastPos      = PosW'(7);
	localparam logic signed [AccW-1:0]   RoundBias    = AccW'(34'sh400);
	localparam logic signed [SumW-1:0]   SampleMax    = SumW'(25'sh7fff);
	localparam logic signed [SumW-1:0]   SampleMin    = -SumW'(25'sh7fff);

	typedef struct packed {
		logic take;
		logic header;
		logic mul_first;
		logic mul_second;
		logic fin;
		logic nib_lo;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic is_header;
	} status_t;

endpackage

@@ src/adpcmd_in_if.sv @@
interface adpcmd_in_if;
	logic                              valid;
	logic                              ready;
	logic [adpcmd_pkg::ByteW-1:0]      adpcm_byte;
	logic                              channel_start;

	modport source (output valid, output adpcm_byte, output channel_start, input ready);
	modport sink (input valid, input adpcm_byte, input channel_start, output ready);
endinterface

@@ src/adpcmd_out_if.sv @@
interface adpcmd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [adpcmd_pkg::SampleW-1:0] first_sample;
	logic signed [adpcmd_pkg::SampleW-1:0] second_sample;
	logic                                 frame_end;

	modport source (output valid, output first_sample, output second_sample,
		output frame_end, input ready);
	modport sink (input valid, input first_sample, input second_sample,
		input frame_end, output ready);
endinterface

@@ src/adpcmd_cfg_if.sv @@
interface adpcmd_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [adpcmd_pkg::CfgIdxW-1:0]      index;
	logic [adpcmd_pkg::CfgDataW-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/adpcmd_ctrl.sv @@
module adpcmd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  adpcmd_pkg::status_t status,
	output adpcmd_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLASS,
		S_MUL1,
		S_MUL2,
		S_FIN,
		S_PUSH
	} state_t;

	state_t state_q;
	logic   nib_q;
	logic   out_valid_q;
	logic   push_ok;

	assign push_ok   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.nib_lo = nib_q;
		unique case (state_q)
			S_IDLE:  cmd.take = in_valid;
			S_CLASS: cmd.header = status.is_header;
			S_MUL1:  cmd.mul_first = 1'b1;
			S_MUL2:  cmd.mul_second = 1'b1;
			S_FIN:   cmd.fin = 1'b1;
			S_PUSH:  cmd.push = push_ok;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nib_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_CLASS;
				end
				S_CLASS: begin
					nib_q <= 1'b0;
					state_q <= status.is_header ? S_IDLE : S_MUL1;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_FIN;
				S_FIN: begin
					nib_q <= 1'b1;
					state_q <= nib_q ? S_PUSH : S_MUL1;
				end
				S_PUSH: begin
					if (push_ok)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ src/adpcmd_datapath.sv @@
module adpcmd_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [adpcmd_pkg::ByteW-1:0]           in_byte,
	input  logic                                   in_start,
	input  logic                                   cfg_we,
	input  logic [adpcmd_pkg::CfgIdxW-1:0]         cfg_idx,
	input  logic [adpcmd_pkg::CfgDataW-1:0]        cfg_data,
	input  adpcmd_pkg::cmd_t                       cmd,
	output adpcmd_pkg::status_t                    status,
	output logic signed [adpcmd_pkg::SampleW-1:0]  first_sample,
	output logic signed [adpcmd_pkg::SampleW-1:0]  second_sample,
	output logic                                   frame_end
);

	localparam int unsigned ProdW   = adpcmd_pkg::ProdW;
	localparam int unsigned AccW    = adpcmd_pkg::AccW;
	localparam int unsigned PredW   = adpcmd_pkg::PredW;
	localparam int unsigned NibShW  = adpcmd_pkg::NibShW;
	localparam int unsigned SumW    = adpcmd_pkg::SumW;
	localparam int unsigned SampleW = adpcmd_pkg::SampleW;
	localparam int unsigned CoefW   = adpcmd_pkg::CoefW;

	logic [adpcmd_pkg::CfgDataW-1:0]       coef_q [adpcmd_pkg::NumBanks];
	logic [adpcmd_pkg::ByteW-1:0]          byte_q;
	logic                                  start_q;
	logic [adpcmd_pkg::PosW-1:0]           pos_q;
	logic [adpcmd_pkg::HdrW-1:0]           sp_q;
	logic signed [SampleW-1:0]             h1_q, h2_q;
	logic signed [ProdW-1:0]               prod_q;
	logic signed [AccW-1:0]                acc_q;
	logic signed [SampleW-1:0]             s0_q, s1_q;
	logic signed [SampleW-1:0]             first_q, second_q;
	logic                                  fe_q, fe_out_q;

	logic [3:0]                            coef_k;
	logic [adpcmd_pkg::CfgDataW-1:0]       bank_sel;
	logic signed [CoefW-1:0]               coef_sel;
	logic signed [SampleW-1:0]             mul_b;
	logic signed [ProdW-1:0]               prod_d;
	logic signed [AccW-1:0]                sum_d;
	logic signed [PredW-1:0]               pred_d;
	logic [adpcmd_pkg::NibW-1:0]           nib;
	logic signed [NibShW-1:0]              nib_sh;
	logic signed [SumW-1:0]                tot_d;
	logic signed [SampleW-1:0]             samp_d;

	assign status.is_header = start_q || (pos_q == '0);

	assign coef_k   = {sp_q[6:4], cmd.mul_second};
	assign bank_sel = coef_q[coef_k[3:2]];
	assign coef_sel = signed'(bank_sel[{coef_k[1:0], 4'b0000} +: CoefW]);
	assign mul_b    = cmd.mul_second ? h2_q : h1_q;
	assign prod_d   = ProdW'(coef_sel) * ProdW'(mul_b);

	assign sum_d  = acc_q + AccW'(prod_q);
	assign pred_d = signed'(sum_d[AccW-1:adpcmd_pkg::PredSh]);
	assign nib    = cmd.nib_lo ? byte_q[3:0] : byte_q[7:4];
	assign nib_sh = NibShW'(signed'(nib)) <<< sp_q[3:0];
	assign tot_d  = SumW'(pred_d) + SumW'(nib_sh);

	always_comb begin
		if (tot_d > adpcmd_pkg::SampleMax)
			samp_d = SampleW'(adpcmd_pkg::SampleMax);
		else if (tot_d < adpcmd_pkg::SampleMin)
			samp_d = SampleW'(adpcmd_pkg::SampleMin);
		else
			samp_d = tot_d[SampleW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < adpcmd_pkg::NumBanks; i++)
				coef_q[i] <= '0;
			pos_q <= '0;
			sp_q  <= '0;
			h1_q  <= '0;
			h2_q  <= '0;
		end else begin
			if (cfg_we && (cfg_idx[adpcmd_pkg::CfgIdxW-1:adpcmd_pkg::BankSelW] == '0))
				coef_q[cfg_idx[adpcmd_pkg::BankSelW-1:0]] <= cfg_data;
			if (cmd.header) begin
				sp_q  <= byte_q[adpcmd_pkg::HdrW-1:0];
				pos_q <= adpcmd_pkg::FirstDataPos;
				if (start_q) begin
					h1_q <= '0;
					h2_q <= '0;
				end
			end
			if (cmd.fin) begin
				h2_q <= h1_q;
				h1_q <= samp_d;
				if (cmd.nib_lo)
					pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q  <= in_byte;
			start_q <= in_start;
		end
		if (cmd.mul_first)
			prod_q <= prod_d;
		if (cmd.mul_second) begin
			acc_q  <= AccW'(prod_q) + adpcmd_pkg::RoundBias;
			prod_q <= prod_d;
		end
		if (cmd.fin) begin
			if (cmd.nib_lo) begin
				s1_q <= samp_d;
				fe_q <= (pos_q == adpcmd_pkg::LastPos);
			end else begin
				s0_q <= samp_d;
			end
		end
		if (cmd.push) begin
			first_q  <= s0_q;
			second_q <= s1_q;
			fe_out_q <= fe_q;
		end
	end

	assign first_sample  = first_q;
	assign second_sample = second_q;
	assign frame_end     = fe_out_q;

endmodule

@@ src/adpcm_nibble_decoder_core.sv @@
// 4-bit DSP ADPCM decoder, one stream byte per input word.
// Channels: adpcm (sink) takes adpcm_byte and channel_start; pcm (source)
// gives first_sample, second_sample and frame_end; cfg (sink) writes the
// four 64-bit coefficient banks by index and is always ready.
// Frames are 8 bytes: a header byte gives no output word, each of the
// seven data bytes gives one word with two samples. channel_start clears
// the history and makes the byte a header.
// Steps: a header byte is taken and classified, then the input is ready
// again. A data byte is classified, then per nibble takes three steps on
// one shared 16x16 multiplier (c1*h1, c2*h2, sum and clamp), then the
// output load. A new byte is taken only after the previous one is done.
// The input is ready again while the last output word waits to be taken;
// if the receiver stalls, the next decoded word holds in the push step
// until the output register frees.
// Reset clears the history, frame position, header and coefficients, and
// empties the output register.
module adpcm_nibble_decoder_core (
	input  logic          clk,
	input  logic          arst_n,
	adpcmd_in_if.sink     adpcm,
	adpcmd_out_if.source  pcm,
	adpcmd_cfg_if.sink    cfg
);

	adpcmd_pkg::cmd_t    cmd;
	adpcmd_pkg::status_t status;

	assign cfg.ready = 1'b1;

	adpcmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (adpcm.valid),
		.in_ready  (adpcm.ready),
		.out_valid (pcm.valid),
		.out_ready (pcm.ready),
		.status    (status),
		.cmd       (cmd)
	);

	adpcmd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_byte       (adpcm.adpcm_byte),
		.in_start      (adpcm.channel_start),
		.cfg_we        (cfg.valid),
		.cfg_idx       (cfg.index),
		.cfg_data      (cfg.data),
		.cmd           (cmd),
		.status        (status),
		.first_sample  (pcm.first_sample),
		.second_sample (pcm.second_sample),
		.frame_end     (pcm.frame_end)
	);

`ifndef SYNTHESIS
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		adpcm.valid && adpcm.ready |=> !adpcm.ready)
		else $error("input ready right after a word was taken");

	a_valid_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pcm.valid) |-> $past(cmd.push))
		else $error("output valid without a push");

	a_sample_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		pcm.valid |-> (pcm.first_sample != 16'sh8000) && (pcm.second_sample != 16'sh8000))
		else $error("sample outside clamp range");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.header, cmd.mul_first, cmd.mul_second, cmd.fin, cmd.push}))
		else $error("more than one datapath step at once");
`endif

endmodule
